FILE: rtl/ptt_pkg.sv
// Shared types and constants for the periodic task timer table.
// No dependencies; imported by every module of the block.
package ptt_pkg;

   localparam int TIME_W = 16;
   localparam int TASK_W = 8;
   localparam int RUNS_W = 8;
   localparam int STEP_W = 8;
   localparam int OP_W   = 2;
   localparam int STAT_W = 3;

   localparam logic [RUNS_W-1:0] RUNS_ENDLESS = 8'd255;

   // Item operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FIRED     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NONE_DUE  = 3'd4;
   localparam logic [STAT_W-1:0] ST_TICK_DONE = 3'd5;

   // One stored table entry (the active and wrapped marks live in flops)
   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] due;
      logic [RUNS_W-1:0] runs;
   } entry_type;

   // Table control from the sequencer
   typedef struct packed {
      logic we;          // write entry and its wrapped mark at the scan slot
      logic set_active;  // mark scan slot active
      logic clr_active;  // free scan slot
      logic clr_wraps;   // clear every wrapped mark
   } tbl_ctl_type;

   // Shared adder request and answer
   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              carry;
   } alu_rsp_type;

endpackage

FILE: rtl/periodic_task_timer_table_top.sv
// Periodic task timer table: a table of TABLE_SLOTS timed tasks on a 16-bit
// microsecond clock, worked by one sequencer that walks the slots one per
// cycle, pausing to re-arm a fired entry or while a held word cannot go out,
// and shares a single 16-bit adder for every due-time, compare and clock sum.
// An item is taken only while the sequencer is idle and one item is handled
// at a time. Add stops at the first free slot; remove and run walk every
// slot, and a run re-arms each fired entry in a step of its own (the re-arm
// sum uses the adder a second time); tick is one adder sum. A run emits one
// word per fired entry in slot order; the last-word flag needs the whole
// walk, so each fired entry is held back until the next one is found or the
// walk ends. The result register frees the input side as soon as it is
// loaded. Reset clears the clock and every active mark; no clearing pass is
// needed.
// Depends on ptt_pkg, ptt_alu and ptt_table.
module periodic_task_timer_table_top #(
   parameter int TABLE_SLOTS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input item channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ptt_pkg::OP_W-1:0]               req_op,
   input  logic [ptt_pkg::TASK_W-1:0]             req_task_id,
   input  logic [ptt_pkg::TIME_W-1:0]             req_delay,
   input  logic [ptt_pkg::RUNS_W-1:0]             req_run_count,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ptt_pkg::STAT_W-1:0]             rsp_status,
   output logic [ptt_pkg::TASK_W-1:0]             rsp_out_task,
   output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] rsp_slot,
   output logic [$clog2(TABLE_SLOTS+1)-1:0]       rsp_removed_count,
   output logic [ptt_pkg::TIME_W-1:0]             rsp_clock_value,
   output logic                                   rsp_last,
   // tick step register write
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ptt_pkg::STEP_W-1:0]             csr_tick_step
);
   import ptt_pkg::*;

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [STEP_W-1:0] STEP_RESET = 8'd5;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ADD    = 7'b0000010,
      S_REMOVE = 7'b0000100,
      S_RUN    = 7'b0001000,
      S_ARM    = 7'b0010000,
      S_TICK   = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   // Sequencer state
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [STEP_W-1:0]  step_ff;

   // Captured item
   logic [OP_W-1:0]    op_ff, op_in;
   logic [TASK_W-1:0]  id_ff, id_in;
   logic [TIME_W-1:0]  delay_ff, delay_in;
   logic [RUNS_W-1:0]  runs_ff, runs_in;

   // Held-back fired entry (run) or chosen slot (add)
   logic               pend_valid_ff, pend_valid_in;
   logic [TASK_W-1:0]  pend_task_ff, pend_task_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;
   logic               out_load;

   // Table and adder hookup
   tbl_ctl_type        tbl_ctl;
   entry_type          wr_entry;
   logic               wr_wrapped;
   entry_type          rd_entry;
   logic               active_bit;
   logic               wrapped_bit;
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   logic               at_last;
   logic               fire;

   ptt_table #(
      .SLOTS  (TABLE_SLOTS),
      .SLOT_W (SLOT_W)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .idx         (idx_ff),
      .rd_idx      (idx_in),
      .ctl         (tbl_ctl),
      .wr_entry    (wr_entry),
      .wr_wrapped  (wr_wrapped),
      .rd_entry    (rd_entry),
      .active_bit  (active_bit),
      .wrapped_bit (wrapped_bit)
   );

   ptt_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // Adder operand select: one sum per cycle
   always_comb begin
      alu_req.a   = time_ff;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      case (state_ff)
         S_ADD:   alu_req.b = delay_ff;
         S_RUN: begin
            alu_req.b   = rd_entry.due;   // clock minus due time
            alu_req.sub = 1'b1;
         end
         S_ARM:   alu_req.b = rd_entry.interval;
         S_TICK:  alu_req.b = {{(TIME_W-STEP_W){1'b0}}, step_ff};
         default: alu_req.b = '0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign at_last   = (idx_ff == LAST_IDX);
   // due: active, not wrapped, signed difference not negative
   assign fire      = active_bit && !wrapped_bit && !alu_rsp.sum[TIME_W-1];
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      time_in       = time_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      delay_in      = delay_ff;
      runs_in       = runs_ff;
      pend_valid_in = pend_valid_ff;
      pend_task_in  = pend_task_ff;
      pend_slot_in  = pend_slot_ff;
      tbl_ctl       = '0;
      wr_entry      = rd_entry;
      wr_wrapped    = alu_rsp.carry;
      out_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               id_in         = req_task_id;
               delay_in      = req_delay;
               runs_in       = (req_run_count == '0) ? RUNS_ENDLESS : req_run_count;
               idx_in        = '0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               case (req_op)
                  OP_ADD:    state_in = S_ADD;
                  OP_REMOVE: state_in = S_REMOVE;
                  OP_RUN:    state_in = S_RUN;
                  OP_TICK:   state_in = S_TICK;
                  default:   state_in = S_TICK;
               endcase
            end
         end

         // first free slot takes the task
         S_ADD: begin
            if (!active_bit) begin
               tbl_ctl.we         = 1'b1;
               tbl_ctl.set_active = 1'b1;
               wr_entry.task_id   = id_ff;
               wr_entry.interval  = delay_ff;
               wr_entry.due       = alu_rsp.sum;
               wr_entry.runs      = runs_ff;
               pend_valid_in      = 1'b1;
               pend_slot_in       = idx_ff;
               state_in           = S_FINISH;
            end else if (at_last) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_REMOVE: begin
            if (active_bit && (rd_entry.task_id == id_ff)) begin
               tbl_ctl.clr_active = 1'b1;
               cnt_in             = cnt_ff + CNT_W'(1);
            end
            if (at_last) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_RUN: begin
            if (fire) begin
               // hold the walk while an earlier fired word cannot go out
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     rsp_status_in = ST_FIRED;
                     rsp_task_in   = pend_task_ff;
                     rsp_slot_in   = pend_slot_ff;
                     rsp_cnt_in    = '0;
                     rsp_time_in   = time_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_task_in  = rd_entry.task_id;
                  pend_slot_in  = idx_ff;
                  state_in      = S_ARM;
               end
            end else if (at_last) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // re-arm from the clock, or free on the last run
         S_ARM: begin
            if (rd_entry.runs > 8'd1) begin
               tbl_ctl.we    = 1'b1;
               wr_entry.due  = alu_rsp.sum;
               wr_entry.runs = (rd_entry.runs == RUNS_ENDLESS) ?
                               RUNS_ENDLESS : rd_entry.runs - 8'd1;
            end else begin
               tbl_ctl.clr_active = 1'b1;
            end
            if (at_last) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RUN;
            end
         end

         S_TICK: begin
            time_in           = alu_rsp.sum;
            tbl_ctl.clr_wraps = alu_rsp.carry;
            state_in          = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_task_in   = '0;
               rsp_slot_in   = '0;
               rsp_cnt_in    = '0;
               rsp_time_in   = time_ff;
               rsp_last_in   = 1'b1;
               case (op_ff)
                  OP_ADD: begin
                     rsp_status_in = pend_valid_ff ? ST_ADDED : ST_FULL;
                     rsp_task_in   = id_ff;
                     rsp_slot_in   = pend_valid_ff ? pend_slot_ff : '0;
                  end
                  OP_REMOVE: begin
                     rsp_status_in = ST_REMOVED;
                     rsp_task_in   = id_ff;
                     rsp_cnt_in    = cnt_ff;
                  end
                  OP_RUN: begin
                     if (pend_valid_ff) begin
                        rsp_status_in = ST_FIRED;
                        rsp_task_in   = pend_task_ff;
                        rsp_slot_in   = pend_slot_ff;
                     end else begin
                        rsp_status_in = ST_NONE_DUE;
                     end
                  end
                  default: rsp_status_in = ST_TICK_DONE;
               endcase
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            step_ff <= csr_tick_step;
         end
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      delay_ff      <= delay_in;
      runs_ff       <= runs_in;
      pend_valid_ff <= pend_valid_in;
      pend_task_ff  <= pend_task_in;
      pend_slot_ff  <= pend_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_task      = rsp_task_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_removed_count = rsp_cnt_ff;
   assign rsp_clock_value   = rsp_time_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

FILE: rtl/ptt_alu.sv
// Shared 16-bit add/subtract unit of the timer table.
// Depends on ptt_pkg.
module ptt_alu (
   input  ptt_pkg::alu_req_type req,
   output ptt_pkg::alu_rsp_type rsp
);
   import ptt_pkg::*;

   logic [TIME_W:0] wide;

   // subtract as a + ~b + 1; carry only meaningful on add
   always_comb begin
      if (req.sub) begin
         wide = {1'b0, req.a} + {1'b0, ~req.b} + {{TIME_W{1'b0}}, 1'b1};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.sum   = wide[TIME_W-1:0];
      rsp.carry = wide[TIME_W];
   end

endmodule

FILE: rtl/ptt_table.sv
// Entry store of the timer table: entry memory with registered read,
// plus active and wrapped marks in flops. Depends on ptt_pkg.
module ptt_table #(
   parameter int SLOTS  = 8,
   parameter int SLOT_W = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SLOT_W-1:0]     idx,
   input  logic [SLOT_W-1:0]     rd_idx,
   input  ptt_pkg::tbl_ctl_type  ctl,
   input  ptt_pkg::entry_type    wr_entry,
   input  logic                  wr_wrapped,
   output ptt_pkg::entry_type    rd_entry,
   output logic                  active_bit,
   output logic                  wrapped_bit
);
   import ptt_pkg::*;

   entry_type        mem [SLOTS];
   entry_type        rd_entry_ff;
   logic [SLOTS-1:0] active_ff;
   logic [SLOTS-1:0] active_in;
   logic [SLOTS-1:0] wrapped_ff;
   logic [SLOTS-1:0] wrapped_in;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[idx] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_idx];
   end

   always_comb begin
      active_in  = active_ff;
      wrapped_in = wrapped_ff;
      if (ctl.set_active) begin
         active_in[idx] = 1'b1;
      end
      if (ctl.clr_active) begin
         active_in[idx] = 1'b0;
      end
      if (ctl.clr_wraps) begin
         wrapped_in = '0;
      end
      if (ctl.we) begin
         wrapped_in[idx] = wr_wrapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
      wrapped_ff <= wrapped_in;
   end

   assign rd_entry    = rd_entry_ff;
   assign active_bit  = active_ff[idx];
   assign wrapped_bit = wrapped_ff[idx];

endmodule

FILE: tb/tb.sv
// Testbench for the periodic task timer table: a directed table, then random
// words under four idling phases; words checked against predictor or typed rows.
// Depends on ptt_pkg and periodic_task_timer_table_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptt_pkg::*;

   localparam int NSLOTS         = 8;
   localparam int SLOT_W         = 3;
   localparam int CNT_W          = 4;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 45;
   localparam int DIR_ROWS       = 25;

   // One result word as the block presents it
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TASK_W-1:0] task_id;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  removed;
      logic [TIME_W-1:0] clk_val;
      logic              last;
   } timer_word_type;

   // Directed rows: predicted, typed-in expectation, or a tick step write
   typedef enum logic [1:0] {ROW_CHECKED, ROW_FIXED, ROW_STEP} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [TASK_W-1:0] id;
      logic [TIME_W-1:0] delay;
      logic [RUNS_W-1:0] runs;   // carries the register value on step rows
      timer_word_type    want;
   } dir_row_type;

   // Clock runs from 0 with step 5 after reset; typed words are read off by hand.
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // empty table: tick, nothing due, remove of an absent id
      '{ROW_FIXED,   OP_TICK,   8'h00, 16'h0000, 8'h00, '{ST_TICK_DONE, 8'h00, 3'd0, 4'd0, 16'd5, 1'b1}},
      '{ROW_FIXED,   OP_RUN,    8'h00, 16'h0000, 8'h00, '{ST_NONE_DUE,  8'h00, 3'd0, 4'd0, 16'd5, 1'b1}},
      '{ROW_FIXED,   OP_REMOVE, 8'h00, 16'h0000, 8'h00, '{ST_REMOVED,   8'h00, 3'd0, 4'd0, 16'd5, 1'b1}},
      // zero delay endless, max delay (wraps), zero delay single run, short
      '{ROW_FIXED,   OP_ADD,    8'hFF, 16'h0000, 8'h00, '{ST_ADDED,     8'hFF, 3'd0, 4'd0, 16'd5, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'h00, 16'hFFFF, 8'hFF, '{ST_ADDED,     8'h00, 3'd1, 4'd0, 16'd5, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'hA5, 16'h0000, 8'h01, '{ST_ADDED,     8'hA5, 3'd2, 4'd0, 16'd5, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'h5A, 16'h0003, 8'h02, '{ST_ADDED,     8'h5A, 3'd3, 4'd0, 16'd5, 1'b1}},
      '{ROW_CHECKED, OP_RUN,    8'h00, 16'h0000, 8'h00, '0},
      '{ROW_FIXED,   OP_TICK,   8'h00, 16'h0000, 8'h00, '{ST_TICK_DONE, 8'h00, 3'd0, 4'd0, 16'd10, 1'b1}},
      '{ROW_CHECKED, OP_RUN,    8'h00, 16'h0000, 8'h00, '0},
      // fill the table, duplicate id in the last slot, then refuse one
      '{ROW_FIXED,   OP_ADD,    8'h11, 16'h8000, 8'h80, '{ST_ADDED,     8'h11, 3'd2, 4'd0, 16'd10, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'h12, 16'h7FFF, 8'h7F, '{ST_ADDED,     8'h12, 3'd4, 4'd0, 16'd10, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'h13, 16'h0001, 8'h03, '{ST_ADDED,     8'h13, 3'd5, 4'd0, 16'd10, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'h14, 16'hAAAA, 8'h55, '{ST_ADDED,     8'h14, 3'd6, 4'd0, 16'd10, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'hFF, 16'h5555, 8'hFE, '{ST_ADDED,     8'hFF, 3'd7, 4'd0, 16'd10, 1'b1}},
      '{ROW_FIXED,   OP_ADD,    8'h77, 16'h0000, 8'h00, '{ST_FULL,      8'h77, 3'd0, 4'd0, 16'd10, 1'b1}},
      '{ROW_FIXED,   OP_REMOVE, 8'hFF, 16'h0000, 8'h00, '{ST_REMOVED,   8'hFF, 3'd0, 4'd2, 16'd10, 1'b1}},
      // zero step adds nothing, then both ends of the legal range
      '{ROW_STEP,    OP_ADD,    8'h00, 16'h0000, 8'd0,   '0},
      '{ROW_FIXED,   OP_TICK,   8'h00, 16'h0000, 8'h00, '{ST_TICK_DONE, 8'h00, 3'd0, 4'd0, 16'd10, 1'b1}},
      '{ROW_STEP,    OP_ADD,    8'h00, 16'h0000, 8'd1,   '0},
      '{ROW_FIXED,   OP_TICK,   8'h00, 16'h0000, 8'h00, '{ST_TICK_DONE, 8'h00, 3'd0, 4'd0, 16'd11, 1'b1}},
      '{ROW_STEP,    OP_ADD,    8'h00, 16'h0000, 8'd255, '0},
      '{ROW_FIXED,   OP_TICK,   8'h00, 16'h0000, 8'h00, '{ST_TICK_DONE, 8'h00, 3'd0, 4'd0, 16'd266, 1'b1}},
      // far-future due times look past on the signed compare
      '{ROW_CHECKED, OP_RUN,    8'h00, 16'h0000, 8'h00, '0},
      '{ROW_CHECKED, OP_REMOVE, 8'h13, 16'h0000, 8'h00, '0}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op;
   logic [TASK_W-1:0]        req_task_id;
   logic [TIME_W-1:0]        req_delay;
   logic [RUNS_W-1:0]        req_run_count;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STAT_W-1:0]        rsp_status;
   logic [TASK_W-1:0]        rsp_out_task;
   logic [SLOT_W-1:0]        rsp_slot;
   logic [CNT_W-1:0]         rsp_removed_count;
   logic [TIME_W-1:0]        rsp_clock_value;
   logic                     rsp_last;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [STEP_W-1:0]        csr_tick_step;

   // Predictor's own copy of the table, clock and tick step
   logic [TIME_W-1:0]        now_us = '0;
   logic [STEP_W-1:0]        step_now = 8'd5;
   bit                       slot_busy    [NSLOTS];
   bit                       slot_wrapped [NSLOTS];
   logic [TASK_W-1:0]        slot_task    [NSLOTS];
   logic [TIME_W-1:0]        slot_period  [NSLOTS];
   logic [TIME_W-1:0]        slot_due     [NSLOTS];
   logic [RUNS_W-1:0]        slot_runs    [NSLOTS];
   timer_word_type           pred_words   [NSLOTS];

   timer_word_type           expected_words [$];

   int src_idle_pct  = 0;
   int rcv_stall_pct = 0;
   int errors        = 0;
   int idle_cycles   = 0;
   int items_sent    = 0;
   int csr_writes    = 0;
   int words_checked = 0;
   int fired_tasks   = 0;
   int refused_adds  = 0;
   int clock_wraps   = 0;

   periodic_task_timer_table_top #(
      .TABLE_SLOTS(NSLOTS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_task_id      (req_task_id),
      .req_delay        (req_delay),
      .req_run_count    (req_run_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_task     (rsp_out_task),
      .rsp_slot         (rsp_slot),
      .rsp_removed_count(rsp_removed_count),
      .rsp_clock_value  (rsp_clock_value),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_tick_step    (csr_tick_step)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Due time is clock plus wait, modulo 2^16; an overflowed sum is marked wrapped
   function automatic void rearm(input int s, input logic [TIME_W-1:0] wait_us);
      logic [TIME_W-1:0] sum;
      sum = now_us + wait_us;
      slot_due[s]     = sum;
      slot_wrapped[s] = (sum < now_us);
   endfunction

   // Applies one accepted item to the table copy, leaves its words in
   // pred_words and returns how many there are.
   function automatic int timer_table_predict(input logic [OP_W-1:0] op,
                                              input logic [TASK_W-1:0] id,
                                              input logic [TIME_W-1:0] delay,
                                              input logic [RUNS_W-1:0] runs);
      int n;
      int freed;
      logic [TIME_W-1:0] prev;
      logic [TIME_W-1:0] diff;
      n = 0;
      freed = 0;
      case (op)
         OP_ADD: begin
            for (int s = 0; s < NSLOTS; s++) begin
               if (!slot_busy[s] && n == 0) begin
                  slot_task[s]   = id;
                  slot_period[s] = delay;
                  rearm(s, delay);
                  slot_runs[s]   = (runs == '0) ? RUNS_ENDLESS : runs;
                  slot_busy[s]   = 1'b1;
                  pred_words[0]  = '{ST_ADDED, id, SLOT_W'(s), '0, now_us, 1'b1};
                  n = 1;
               end
            end
            if (n == 0) begin
               // table full: nothing changes, the id comes back refused
               pred_words[0] = '{ST_FULL, id, '0, '0, now_us, 1'b1};
               refused_adds++;
               n = 1;
            end
         end
         OP_REMOVE: begin
            for (int s = 0; s < NSLOTS; s++) begin
               if (slot_busy[s] && slot_task[s] == id) begin
                  slot_busy[s] = 1'b0;
                  freed++;
               end
            end
            pred_words[0] = '{ST_REMOVED, id, '0, CNT_W'(freed), now_us, 1'b1};
            n = 1;
         end
         OP_RUN: begin
            for (int s = 0; s < NSLOTS; s++) begin
               diff = now_us - slot_due[s];
               if (slot_busy[s] && !slot_wrapped[s] && !diff[TIME_W-1]) begin
                  pred_words[n] = '{ST_FIRED, slot_task[s], SLOT_W'(s), '0, now_us, 1'b0};
                  n++;
                  fired_tasks++;
                  if (slot_runs[s] > 1) begin
                     if (slot_runs[s] != RUNS_ENDLESS)
                        slot_runs[s] = slot_runs[s] - 1'b1;
                     rearm(s, slot_period[s]);
                  end else begin
                     slot_busy[s] = 1'b0;   // last run frees the slot
                  end
               end
            end
            if (n == 0) begin
               pred_words[0] = '{ST_NONE_DUE, '0, '0, '0, now_us, 1'b1};
               n = 1;
            end else begin
               pred_words[n-1].last = 1'b1;
            end
         end
         default: begin
            prev   = now_us;
            now_us = now_us + step_now;
            if (now_us < prev) begin
               // clock wrapped: wrapped entries become comparable again
               foreach (slot_wrapped[s]) slot_wrapped[s] = 1'b0;
               clock_wraps++;
            end
            pred_words[0] = '{ST_TICK_DONE, '0, '0, '0, now_us, 1'b1};
            n = 1;
         end
      endcase
      return n;
   endfunction

   function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                       input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Presents one item from the falling edge, with random idle cycles first,
   // and holds it until the block takes it. Valid is left high afterwards so
   // that back-to-back words need no gap.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id,
                            input logic [TIME_W-1:0] delay, input logic [RUNS_W-1:0] runs,
                            input bit typed, input timer_word_type want);
      int n;
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_op        = op;
      req_task_id   = id;
      req_delay     = delay;
      req_run_count = runs;
      do @(posedge clock); while (req_stall);
      n = timer_table_predict(op, id, delay, runs);
      if (typed)
         expected_words.push_back(want);
      else
         for (int i = 0; i < n; i++) expected_words.push_back(pred_words[i]);
      items_sent++;
   endtask

   // Drops valid, waits for every expected word, then lets the block settle
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tick_step(input logic [STEP_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid     = 1'b1;
      csr_tick_step = value;
      do @(posedge clock); while (!csr_ready);
      step_now = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver stall, redrawn every falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);

   // Result checker: each taken word against the oldest expectation
   always @(posedge clock) begin
      timer_word_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: status %0d task %0d", rsp_status, rsp_out_task);
            errors++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            check_field("status",        want.status,  rsp_status);
            check_field("out_task",      want.task_id, rsp_out_task);
            check_field("slot",          want.slot,    rsp_slot);
            check_field("removed_count", want.removed, rsp_removed_count);
            check_field("clock_value",   want.clk_val, rsp_clock_value);
            check_field("last",          want.last,    rsp_last);
         end
      end
   end

   // Watchdog: any handshake on any channel resets the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                  idle_cycles, expected_words.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int                r;
      int                n;
      logic [OP_W-1:0]   op;
      logic [TASK_W-1:0] id;
      logic [TIME_W-1:0] delay;
      logic [RUNS_W-1:0] runs;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_ADD;
      req_task_id   = '0;
      req_delay     = '0;
      req_run_count = '0;
      csr_valid     = 1'b0;
      csr_tick_step = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, light idling on both sides
      src_idle_pct  = 20;
      rcv_stall_pct = 20;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_STEP)
            write_tick_step(DIRECTED[i].runs);
         else
            send_item(DIRECTED[i].op, DIRECTED[i].id, DIRECTED[i].delay, DIRECTED[i].runs,
                      DIRECTED[i].kind == ROW_FIXED, DIRECTED[i].want);
      end

      // Random phases, each at its own tick step
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  write_tick_step(8'd1);   end
            1: begin src_idle_pct = 46; rcv_stall_pct = 0;  write_tick_step(8'd255); end
            2: begin
               src_idle_pct = 0;  rcv_stall_pct = 46;
               write_tick_step(STEP_W'($urandom_range(2, 254)));
            end
            default: begin
               src_idle_pct = 34; rcv_stall_pct = 34;
               write_tick_step(STEP_W'($urandom_range(1, 255)));
            end
         endcase
         n = 0;
         while (n < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            op = (r < 35) ? OP_ADD : (r < 50) ? OP_REMOVE : (r < 80) ? OP_RUN : OP_TICK;
            // a small id pool so removes and duplicates hit live entries
            id = ($urandom_range(0, 99) < 85) ? TASK_W'($urandom_range(0, 7))
                                              : TASK_W'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 10)      delay = '0;
            else if (r < 80) delay = TIME_W'($urandom_range(0, 4 * step_now + 3));
            else if (r < 95) delay = TIME_W'($urandom_range(0, 65535));
            else             delay = '1;
            r = $urandom_range(0, 99);
            if (r < 20)      runs = '0;
            else if (r < 40) runs = RUNS_ENDLESS;
            else if (r < 80) runs = RUNS_W'($urandom_range(1, 4));
            else             runs = RUNS_W'($urandom_range(0, 255));
            send_item(op, id, delay, runs, 1'b0, '0);
            n++;
         end
      end

      drain();
      $display("Run covered %0d items and %0d tick step writes; %0d result words checked,",
               items_sent, csr_writes, words_checked);
      $display("  including %0d fired tasks, %0d refused adds and %0d clock wraps.",
               fired_tasks, refused_adds, clock_wraps);
      if (errors == 0 && expected_words.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/ptt_pkg.sv
rtl/ptt_alu.sv
rtl/ptt_table.sv
rtl/periodic_task_timer_table_top.sv
tb/tb.sv
